// ===== rtl/core/bfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bitmap font text renderer.
// No dependencies; every other file in rtl/core imports this package.
package bfr_pkg;

    localparam int ADDR_W     = 48;
    localparam int DIM_W      = 13;
    localparam int LINE_W     = 12;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PROD_W     = LINE_W + DIM_W;

    localparam int CELL_WIDTH  = 8;
    localparam int LINE_HEIGHT = 16;
    localparam int ROWS_DRAWN  = 16;

    localparam logic [3:0] ROW_LAST = 4'(ROWS_DRAWN - 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PRINT = 1'b1;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 3'd5;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        logic [3:0] glyph_row;
        logic [7:0] row_bits;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pix0_color;
        logic [COLOR_W-1:0] pix1_color;
        logic [COLOR_W-1:0] pix2_color;
        logic [COLOR_W-1:0] pix3_color;
        logic [COLOR_W-1:0] pix4_color;
        logic [COLOR_W-1:0] pix5_color;
        logic [COLOR_W-1:0] pix6_color;
        logic [COLOR_W-1:0] pix7_color;
        logic               last_row;
    } t_out_item;

    typedef struct packed {
        logic       en;
        logic [7:0] code;
        logic [3:0] row;
        logic [7:0] bits;
    } t_font_wr;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_PROD,
        ACC_ADD_STRIDE
    } t_acc_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_ROW
    } t_state;

endpackage

// ===== rtl/core/bfr_font_mem.sv =====
`timescale 1ns / 1ps
// Glyph row store: one write port, one registered read port.
// Depends on bfr_pkg.
module bfr_font_mem
    import bfr_pkg::*;
#(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16
) (
    input  logic       i_clk,
    input  t_font_wr   i_wr,
    input  logic [7:0] i_rd_code,
    input  logic [3:0] i_rd_row,
    output logic [7:0] o_rd_bits
);

    localparam int STORE = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(STORE);
    localparam int IW    = $clog2(STORE + ROWS_DRAWN) + 1;

    logic [7:0]    r_mem [STORE];
    logic [7:0]    r_q;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // code mod glyph count, times rows per glyph, plus row, mod store size;
    // each mod needs one conditional subtract for the allowed ranges
    function automatic logic [AW-1:0] f_index(input logic [7:0] code, input logic [3:0] row);
        logic [IW-1:0] c;
        logic [IW-1:0] idx;
        c = IW'(code);
        if (c >= IW'(GLYPH_COUNT)) c = c - IW'(GLYPH_COUNT);
        idx = c * IW'(GLYPH_ROWS) + IW'(row);
        if (idx >= IW'(STORE)) idx = idx - IW'(STORE);
        return idx[AW-1:0];
    endfunction

    assign wr_addr = f_index(i_wr.code, i_wr.row);
    assign rd_addr = f_index(i_rd_code, i_rd_row);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[rd_addr];
    end

    assign o_rd_bits = r_q;

endmodule

// ===== rtl/core/bfr_addr_unit.sv =====
`timescale 1ns / 1ps
// Shared address accumulator: one line*stride multiply and one 48-bit adder
// stepped by the sequencer. Depends on bfr_pkg.
module bfr_addr_unit
    import bfr_pkg::*;
(
    input  logic              i_clk,
    input  t_acc_op           i_op,
    input  logic [ADDR_W-1:0] i_frame_base,
    input  logic [DIM_W-1:0]  i_col,
    input  logic [LINE_W-1:0] i_line,
    input  logic [DIM_W-1:0]  i_stride,
    output logic [ADDR_W-1:0] o_addr
);

    logic [PROD_W-1:0] r_prod;
    logic [ADDR_W-1:0] r_acc;
    logic [ADDR_W-1:0] n_acc;
    logic [ADDR_W-1:0] opnd_a;
    logic [ADDR_W-1:0] opnd_b;
    logic [ADDR_W-1:0] sum;

    // pixel offsets scale by 4 bytes per pixel
    always_comb begin
        opnd_a = r_acc;
        opnd_b = ADDR_W'({i_stride, 2'b00});
        case (i_op)
            ACC_LOAD: begin
                opnd_a = i_frame_base;
                opnd_b = ADDR_W'({i_col, 2'b00});
            end
            ACC_ADD_PROD: begin
                opnd_b = ADDR_W'({r_prod, 2'b00});
            end
            default: begin
            end
        endcase
    end

    assign sum = opnd_a + opnd_b;

    always_comb begin
        case (i_op)
            ACC_HOLD: n_acc = r_acc;
            default:  n_acc = sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_line) * PROD_W'(i_stride);
        r_acc  <= n_acc;
    end

    assign o_addr = r_acc;

endmodule

// ===== rtl/core/bitmap_font_text_renderer.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Word
// in       input      i_in_valid / o_in_ready    t_in_item  (load row or print char)
// out      output     o_out_valid / i_out_ready  t_out_item (one glyph row write)
// cfg      input      i_cfg_valid / o_cfg_ready  index + data (register write)
//
// A load or a newline is finished when it is accepted. A printed character
// goes through its accept, the setup states ST_MUL and ST_BASE (multiply
// line*stride, form the base address) and 16 glyph row writes through the
// shared address adder. A stalled output holds the row sequencer.
// Reset (i_rst_n low, synchronous) clears cursor, sequencer and registers;
// the font store is not cleared and must be loaded before use.
// Depends on bfr_pkg, bfr_font_mem, bfr_addr_unit.
module bitmap_font_text_renderer
    import bfr_pkg::*;
#(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ADDR_W-1:0]  r_frame_base;
    logic [DIM_W-1:0]   r_screen_width;
    logic [DIM_W-1:0]   r_screen_height;
    logic [DIM_W-1:0]   r_line_stride;
    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;

    t_state            r_state;
    t_state            n_state;
    logic [DIM_W-1:0]  r_col;
    logic [DIM_W-1:0]  n_col;
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    logic [LINE_W-1:0] nl_line;
    logic [3:0]        r_row;
    logic [3:0]        n_row;
    logic [7:0]        r_code;
    logic [7:0]        n_code;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic        in_fire;
    logic        out_free;
    logic        row_fire;
    logic        cfg_fire;
    t_acc_op     acc_op;
    t_font_wr    font_wr;
    logic [7:0]  glyph_bits;
    logic [ADDR_W-1:0] row_addr;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign row_fire    = (r_state == ST_ROW) && out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base    <= '0;
            r_screen_width  <= DIM_W'(640);
            r_screen_height <= DIM_W'(480);
            r_line_stride   <= DIM_W'(640);
            r_fg_color      <= '1;
            r_bg_color      <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                CFG_FRAME_BASE:    r_frame_base    <= i_cfg_data[ADDR_W-1:0];
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[DIM_W-1:0];
                CFG_LINE_STRIDE:   r_line_stride   <= i_cfg_data[DIM_W-1:0];
                CFG_FG_COLOR:      r_fg_color      <= i_cfg_data[COLOR_W-1:0];
                CFG_BG_COLOR:      r_bg_color      <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign font_wr.en   = in_fire && (i_in_data.op == OP_LOAD);
    assign font_wr.code = i_in_data.char_code;
    assign font_wr.row  = i_in_data.glyph_row;
    assign font_wr.bits = i_in_data.row_bits;

    // line advance stays on the last line when no room is left below
    assign nl_line = ((DIM_W'(r_line) + DIM_W'(LINE_HEIGHT)) < r_screen_height)
                     ? r_line + LINE_W'(LINE_HEIGHT) : r_line;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_line      = r_line;
        n_row       = r_row;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        acc_op      = ACC_HOLD;
        case (r_state)
            ST_IDLE: begin
                n_row = '0;
                if (in_fire && (i_in_data.op == OP_PRINT)) begin
                    n_code = i_in_data.char_code;
                    if (i_in_data.char_code == CH_LF) begin
                        n_line = nl_line;
                        n_col  = '0;
                    end else begin
                        n_state = ST_MUL;
                        if (i_in_data.char_code == CH_CR) begin
                            n_col = '0;
                        end else if ((14'(r_col) + 14'(CELL_WIDTH)) > 14'(r_screen_width)) begin
                            n_col  = '0;
                            n_line = nl_line;
                        end
                    end
                end
            end
            ST_MUL: begin
                acc_op  = ACC_LOAD;
                n_state = ST_BASE;
            end
            ST_BASE: begin
                acc_op  = ACC_ADD_PROD;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                if (row_fire) begin
                    acc_op      = ACC_ADD_STRIDE;
                    n_out_valid = 1'b1;
                    n_out.pixel_address = row_addr;
                    n_out.pix0_color = glyph_bits[7] ? r_fg_color : r_bg_color;
                    n_out.pix1_color = glyph_bits[6] ? r_fg_color : r_bg_color;
                    n_out.pix2_color = glyph_bits[5] ? r_fg_color : r_bg_color;
                    n_out.pix3_color = glyph_bits[4] ? r_fg_color : r_bg_color;
                    n_out.pix4_color = glyph_bits[3] ? r_fg_color : r_bg_color;
                    n_out.pix5_color = glyph_bits[2] ? r_fg_color : r_bg_color;
                    n_out.pix6_color = glyph_bits[1] ? r_fg_color : r_bg_color;
                    n_out.pix7_color = glyph_bits[0] ? r_fg_color : r_bg_color;
                    n_out.last_row   = (r_row == ROW_LAST);
                    if (r_row == ROW_LAST) begin
                        n_row   = '0;
                        n_col   = r_col + DIM_W'(CELL_WIDTH);
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_line      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_line      <= n_line;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_out  <= n_out;
    end

    // read follows the next row so the byte for r_row is ready each cycle
    bfr_font_mem #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_font_mem (
        .i_clk     (i_clk),
        .i_wr      (font_wr),
        .i_rd_code (r_code),
        .i_rd_row  (n_row),
        .o_rd_bits (glyph_bits)
    );

    bfr_addr_unit u_addr_unit (
        .i_clk        (i_clk),
        .i_op         (acc_op),
        .i_frame_base (r_frame_base),
        .i_col        (r_col),
        .i_line       (r_line),
        .i_stride     (r_line_stride),
        .o_addr       (row_addr)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idle_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_row == 4'd0))
        else $error("row counter not cleared while idle");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_fire && (r_row == ROW_LAST))
        |=> ((r_state == ST_IDLE) && o_out_valid && o_out_data.last_row))
        else $error("final glyph row did not end the character");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_fire && (r_row != ROW_LAST))
        |=> ((r_state == ST_ROW) && (r_row == $past(r_row) + 4'd1)
             && !o_out_data.last_row))
        else $error("row sequencer skipped or stalled after a row write");

    a_setup_to_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_BASE) ##1 (r_state == ST_ROW))
        else $error("address setup sequence broken");
`endif

endmodule

// ===== dv/bitmap_font_text_renderer_test.sv =====
`timescale 1ns / 1ps
// Self-checking test for bitmap_font_text_renderer: a scoreboard class predicts glyph row writes.
// Loads fonts, prints under several screen settings, idles both sides. Depends on bfr_pkg.
module bitmap_font_text_renderer_test;
    import bfr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 12;
    localparam int SETTLE       = 40;

    localparam logic [7:0] GLYPH_BLANK = 8'h00;
    localparam logic [7:0] GLYPH_SOLID = 8'hFF;
    localparam logic [7:0] GLYPH_ODD   = 8'h55;
    localparam logic [7:0] GLYPH_EVEN  = 8'hAA;

    localparam logic [7:0] PRELOAD [5] = '{GLYPH_BLANK, CH_CR, GLYPH_SOLID, GLYPH_ODD, GLYPH_EVEN};
    localparam logic [7:0] DIRECT_DEFAULT [8] =
        '{GLYPH_BLANK, GLYPH_SOLID, GLYPH_ODD, CH_CR, CH_LF, GLYPH_EVEN, CH_LF, CH_CR};
    localparam logic [7:0] DIRECT_TINY [6] =
        '{GLYPH_ODD, GLYPH_EVEN, CH_LF, CH_CR, GLYPH_SOLID, GLYPH_BLANK};
    localparam logic [7:0] DIRECT_HUGE [7] =
        '{GLYPH_ODD, CH_LF, CH_LF, CH_LF, GLYPH_SOLID, CH_CR, GLYPH_EVEN};

    class glyph_row_scoreboard;
        logic [ADDR_W-1:0]  frame_addr;
        logic [DIM_W-1:0]   vis_width;
        logic [DIM_W-1:0]   vis_height;
        logic [DIM_W-1:0]   pitch;
        logic [COLOR_W-1:0] ink;
        logic [COLOR_W-1:0] paper;
        logic [DIM_W-1:0]   col;
        logic [LINE_W-1:0]  row_top;
        logic [7:0]         glyph_bytes [4096];
        t_out_item          rows_due [$];
        int                 errors;
        int                 rows_checked;

        function new();
            frame_addr   = '0;
            vis_width    = 13'd640;
            vis_height   = 13'd480;
            pitch        = 13'd640;
            ink          = 32'hFFFF_FFFF;
            paper        = '0;
            col          = '0;
            row_top      = '0;
            errors       = 0;
            rows_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_BASE:    frame_addr = val[ADDR_W-1:0];
                CFG_SCREEN_WIDTH:  vis_width  = val[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: vis_height = val[DIM_W-1:0];
                CFG_LINE_STRIDE:   pitch      = val[DIM_W-1:0];
                CFG_FG_COLOR:      ink        = val[COLOR_W-1:0];
                CFG_BG_COLOR:      paper      = val[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function void next_line();
            // stay on the last line once there is no room for another
            if (int'(row_top) + LINE_HEIGHT < int'(vis_height))
                row_top = row_top + LINE_W'(LINE_HEIGHT);
            col = '0;
        endfunction

        function void accept_word(t_in_item w);
            t_out_item          row_word;
            logic [7:0]         g;
            logic [7:0][31:0]   cols;
            longint unsigned    pix;
            if (w.op == OP_LOAD) begin
                glyph_bytes[{w.char_code, w.glyph_row}] = w.row_bits;
                return;
            end
            if (w.char_code == CH_LF) begin
                next_line();
                return;
            end
            // carriage return clears the column, then draws its glyph anyway
            if (w.char_code == CH_CR)
                col = '0;
            else if (int'(col) + CELL_WIDTH > int'(vis_width))
                next_line();
            for (int r = 0; r < ROWS_DRAWN; r++) begin
                g = glyph_bytes[{w.char_code, 4'(r)}];
                pix = longint'(col) + (longint'(row_top) + r) * longint'(pitch);
                row_word.pixel_address = ADDR_W'(frame_addr + pix * 4);
                for (int k = 0; k < 8; k++)
                    cols[k] = g[k] ? ink : paper;
                {row_word.pix0_color, row_word.pix1_color, row_word.pix2_color,
                 row_word.pix3_color, row_word.pix4_color, row_word.pix5_color,
                 row_word.pix6_color, row_word.pix7_color} = cols;
                row_word.last_row = (r == ROWS_DRAWN - 1);
                rows_due.push_back(row_word);
            end
            col = col + DIM_W'(CELL_WIDTH);
        endfunction

        function void report(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            errors++;
            $display("%0t: row write %0d %s expected %h, got %h",
                     $time, rows_checked, field, want, got);
        endfunction

        function void check_row(t_out_item got);
            t_out_item        want;
            logic [7:0][31:0] wc;
            logic [7:0][31:0] gc;
            if (rows_due.size() == 0) begin
                errors++;
                $display("%0t: row write with none expected, expected nothing, got address %h",
                         $time, got.pixel_address);
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            wc = {want.pix0_color, want.pix1_color, want.pix2_color, want.pix3_color,
                  want.pix4_color, want.pix5_color, want.pix6_color, want.pix7_color};
            gc = {got.pix0_color, got.pix1_color, got.pix2_color, got.pix3_color,
                  got.pix4_color, got.pix5_color, got.pix6_color, got.pix7_color};
            if (got.pixel_address !== want.pixel_address)
                report("pixel_address", want.pixel_address, got.pixel_address);
            for (int i = 0; i < 8; i++)
                if (gc[7-i] !== wc[7-i])
                    report($sformatf("pix%0d_color", i), ADDR_W'(wc[7-i]), ADDR_W'(gc[7-i]));
            if (got.last_row !== want.last_row)
                report("last_row", ADDR_W'(want.last_row), ADDR_W'(got.last_row));
        endfunction

        function int pending();
            return rows_due.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  o_cfg_ready;

    glyph_row_scoreboard sb;

    bit [15:0]   glyph_mask  [256];
    bit          glyph_ready [256];
    logic [7:0]  printable [$];
    int          burst_left;
    int          n_loads;
    int          n_prints;
    int          n_settings;
    int          cycles;

    bit          start_long_hold;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned seg_left;
    int          seg_mode;

    bitmap_font_text_renderer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d row writes outstanding", $time, sb.pending());
            $display("bitmap_font_text_renderer_test failed");
            $finish;
        end
    end

    // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus one long hold.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (start_long_hold && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= 400;
            i_out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_mode <= $urandom_range(0, 2);
                seg_left <= $urandom_range(4, 60);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_row(o_out_data);
    end

    task automatic send_word(input t_in_item w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.accept_word(w);
        if (w.op == OP_LOAD) begin
            n_loads++;
            glyph_mask[w.char_code][w.glyph_row] = 1'b1;
            if (&glyph_mask[w.char_code] && !glyph_ready[w.char_code]) begin
                glyph_ready[w.char_code] = 1'b1;
                printable.push_back(w.char_code);
            end
        end else begin
            n_prints++;
        end
    endtask

    task automatic print_char(input logic [7:0] code);
        t_in_item w;
        w.op        = OP_PRINT;
        w.char_code = code;
        w.glyph_row = 4'($urandom);
        w.row_bits  = 8'($urandom);
        send_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        // loads and newlines leave no row write behind; give them time to retire
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input int w, input int h,
                             input int pitch, input logic [COLOR_W-1:0] fg,
                             input logic [COLOR_W-1:0] bg);
        logic [CFG_DATA_W-1:0] vals [6];
        vals[CFG_FRAME_BASE]    = base;
        vals[CFG_SCREEN_WIDTH]  = CFG_DATA_W'(w);
        vals[CFG_SCREEN_HEIGHT] = CFG_DATA_W'(h);
        vals[CFG_LINE_STRIDE]   = CFG_DATA_W'(pitch);
        vals[CFG_FG_COLOR]      = CFG_DATA_W'(fg);
        vals[CFG_BG_COLOR]      = CFG_DATA_W'(bg);
        drain();
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic random_item();
        t_in_item w;
        int       pick;
        pick        = $urandom_range(0, 99);
        w.op        = OP_PRINT;
        w.glyph_row = 4'($urandom);
        w.row_bits  = 8'($urandom);
        if (pick < 20) begin
            // overwrite a live glyph half the time, else load a row of a random code
            w.op        = OP_LOAD;
            w.char_code = $urandom_range(0, 1) ? printable[$urandom_range(0, printable.size() - 1)]
                                               : 8'($urandom);
        end else if (pick < 34) begin
            w.char_code = CH_LF;
        end else if (pick < 44) begin
            w.char_code = CH_CR;
        end else begin
            w.char_code = printable[$urandom_range(0, printable.size() - 1)];
        end
        send_word(w);
    endtask

    initial begin
        t_in_item w;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PRELOAD[g]) begin
            for (int r = 0; r < ROWS_DRAWN; r++) begin
                w.op        = OP_LOAD;
                w.char_code = PRELOAD[g];
                w.glyph_row = 4'(r);
                case (PRELOAD[g])
                    GLYPH_BLANK: w.row_bits = r[0] ? 8'hFF : 8'h00;
                    GLYPH_SOLID: w.row_bits = r[0] ? 8'h00 : 8'hFF;
                    CH_CR:       w.row_bits = (r < 8) ? (8'h80 >> r) : (8'h01 << (r - 8));
                    default:     w.row_bits = 8'($urandom);
                endcase
                send_word(w);
            end
        end

        foreach (DIRECT_DEFAULT[i]) print_char(DIRECT_DEFAULT[i]);

        // smallest screen, base near the top of the address space
        configure(48'hFFFF_FFFF_FFF0, 8, 16, 8, 32'h0000_0000, 32'hFFFF_FFFF);
        foreach (DIRECT_TINY[i]) print_char(DIRECT_TINY[i]);

        configure(ADDR_W'({$urandom, $urandom}), 4096, 4096, 4096, $urandom, $urandom);
        // hold the output off while these words keep coming
        start_long_hold <= 1'b1;
        foreach (DIRECT_HUGE[i]) print_char(DIRECT_HUGE[i]);

        configure(ADDR_W'({$urandom, $urandom}), $urandom_range(8, 96), $urandom_range(16, 80),
                  $urandom_range(8, 4096), $urandom, $urandom);
        repeat (RANDOM_ITEMS / 4) random_item();

        configure(ADDR_W'({$urandom, $urandom}), $urandom_range(8, 4096),
                  $urandom_range(16, 4096), $urandom_range(8, 4096), $urandom, $urandom);
        repeat (RANDOM_ITEMS / 4) random_item();

        configure(48'h0, 4096, 4096, 4096, 32'hFFFF_FFFF, 32'h0000_0000);
        repeat (RANDOM_ITEMS / 4) random_item();

        configure(ADDR_W'({$urandom, $urandom}), $urandom_range(8, 40), $urandom_range(16, 4096),
                  $urandom_range(8, 64), $urandom, $urandom);
        repeat (RANDOM_ITEMS / 4) random_item();

        drain();
        $display("Run covered %0d font loads and %0d print commands over %0d screen settings;",
                 n_loads, n_prints, n_settings + 1);
        $display("%0d glyph row writes checked, %0d mismatches.", sb.rows_checked, sb.errors);
        if (sb.errors == 0)
            $display("bitmap_font_text_renderer_test passed");
        else
            $display("bitmap_font_text_renderer_test failed");
        $finish;
    end

endmodule
